FILE: rtl/odometer_with_slot_journal_unit_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ODOMETER_WITH_SLOT_JOURNAL_UNIT_MACROS_SVH
`define ODOMETER_WITH_SLOT_JOURNAL_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define OWSJ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("owsj assertion failed");

// Next-cycle implication.
`define OWSJ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("owsj assertion failed");

`endif

FILE: rtl/owsj_pkg.sv
package owsj_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [15:0] REC_MAGIC  = 16'h4F44;
    localparam logic [9:0]  MM_PER_M   = 10'd1000;
    localparam logic [11:0] SEC_PER_H  = 12'd3600;
    localparam logic [15:0] BASE_RESET = 16'h0040;
    localparam logic [15:0] DIST_RESET = 16'd100;
    localparam logic [15:0] INTV_RESET = 16'd60;
    localparam int          SLOT_BYTES_SH = 4;

    // Millimetres to metres: floor(mm * MM_RECIP / 2^MM_RECIP_SH) equals
    // floor(mm / 1000) for every 32-bit mm.
    localparam logic [31:0] MM_RECIP    = 32'h1062_4DD3;
    localparam int          MM_RECIP_SH = 38;

    // Divider width: trip metres times 3600 fits in 44 bits.
    localparam int DIV_W   = 44;
    localparam int DIV_CW  = $clog2(DIV_W + 1);

    localparam logic [2:0] FN_ADD     = 3'd0;
    localparam logic [2:0] FN_TICK    = 3'd1;
    localparam logic [2:0] FN_SAVE    = 3'd2;
    localparam logic [2:0] FN_TRIPCLR = 3'd3;
    localparam logic [2:0] FN_WDONE   = 3'd4;
    localparam logic [2:0] FN_OFFER   = 3'd5;
    localparam logic [2:0] FN_FINISH  = 3'd6;

    localparam logic [1:0] CFG_DIST = 2'd0;
    localparam logic [1:0] CFG_INTV = 2'd1;
    localparam logic [1:0] CFG_BASE = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [7:0] byte_sum32(input logic [31:0] w);
        byte_sum32 = w[7:0] + w[15:8] + w[23:16] + w[31:24];
    endfunction

    // Negated byte sum of the packed 15-byte record body.
    function automatic logic [7:0] rec_csum(input logic [15:0] magic, input logic [31:0] seq,
                                            input logic [31:0] tot, input logic [31:0] trp,
                                            input logic [7:0] rsv);
        logic [7:0] s;
        s = magic[7:0] + magic[15:8] + byte_sum32(seq) + byte_sum32(tot)
            + byte_sum32(trp) + rsv;
        rec_csum = 8'(8'd0 - s);
    endfunction

endpackage

FILE: rtl/owsj_req_if.sv
interface owsj_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] distance_mm;
    logic        write_ok;
    logic [2:0]  offered_slot;
    logic [15:0] rec_magic;
    logic [31:0] rec_seq;
    logic [31:0] rec_total;
    logic [31:0] rec_trip;
    logic [7:0]  rec_reserved;
    logic [7:0]  rec_checksum;

    modport source (output valid, func, distance_mm, write_ok, offered_slot, rec_magic,
                    rec_seq, rec_total, rec_trip, rec_reserved, rec_checksum,
                    input ready);
    modport sink (input valid, func, distance_mm, write_ok, offered_slot, rec_magic,
                  rec_seq, rec_total, rec_trip, rec_reserved, rec_checksum,
                  output ready);
endinterface

FILE: rtl/owsj_rsp_if.sv
interface owsj_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] total_metres;
    logic [31:0] trip_metres;
    logic [31:0] trip_seconds;
    logic [15:0] trip_avg_kmh;
    logic        save_request;
    logic [15:0] save_address;
    logic [31:0] save_seq;
    logic [7:0]  save_checksum;
    logic        restore_found;

    modport source (output valid, total_metres, trip_metres, trip_seconds, trip_avg_kmh,
                    save_request, save_address, save_seq, save_checksum, restore_found,
                    input ready);
    modport sink (input valid, total_metres, trip_metres, trip_seconds, trip_avg_kmh,
                  save_request, save_address, save_seq, save_checksum, restore_found,
                  output ready);
endinterface

FILE: rtl/owsj_div.sv
module owsj_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [owsj_pkg::DIV_W-1:0]      i_num,
    input  logic [owsj_pkg::DIV_W-1:0]      i_den,
    output logic [owsj_pkg::DIV_W-1:0]      o_quo,
    output owsj_pkg::t_div_stat             o_stat
);
    // Restoring divider, one quotient bit per cycle.
    logic [owsj_pkg::DIV_W:0]    r_rem, n_rem;
    logic [owsj_pkg::DIV_W-1:0]  r_quo, n_quo;
    logic [owsj_pkg::DIV_W-1:0]  r_den;
    logic [owsj_pkg::DIV_CW-1:0] r_cnt;
    logic                        r_busy, r_done;
    logic [owsj_pkg::DIV_W:0]    trial;

    always_comb begin
        trial = {r_rem[owsj_pkg::DIV_W-1:0], r_quo[owsj_pkg::DIV_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = trial - {1'b0, r_den};
            n_quo = {r_quo[owsj_pkg::DIV_W-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_quo = {r_quo[owsj_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= owsj_pkg::DIV_CW'(owsj_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == owsj_pkg::DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

FILE: rtl/odometer_with_slot_journal_unit.sv
// Odometer with a ring journal of saved records.
// Requests arrive on i_req (valid/ready): a function code plus its operands.
// Each accepted request produces exactly one response on o_rsp, carrying the
// counters after the request, the trip average speed and any save request.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data;
// the user must write them only while the block is idle, as the block does not
// enforce it; a write takes effect at once. A request passes through S_APPLY
// and S_MUL to S_OUT, where the response is offered; a request that adds
// distance first passes through S_MMCONV, turning millimetres into metres with
// a reciprocal multiply. With trip seconds nonzero, S_AVGGO then starts the
// 44-bit restoring divider for the average speed, which produces one quotient
// bit per cycle and takes most of the time, and S_DIVAVG waits for it. When
// trip seconds are zero the divider is skipped and S_OUT follows S_MUL. The
// block takes one request at a time: i_req.ready is high only when idle, so a
// new request is taken only after the response on o_rsp has been accepted.
// If the receiver stalls, the response is held unchanged in the output
// register and no new request is taken until it is accepted.
// After reset all counters and the journal state are zero and the
// configuration registers hold their defaults; the block is ready at once.
`include "odometer_with_slot_journal_unit_macros.svh"
module odometer_with_slot_journal_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    owsj_req_if.sink    i_req,
    owsj_rsp_if.source  o_rsp
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MMCONV = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_AVGGO  = 3'd4;
    localparam logic [2:0] S_DIVAVG = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    localparam int SW = owsj_pkg::SLOT_W;
    localparam int DW = owsj_pkg::DIV_W;

    logic [2:0] r_state;

    // Configuration registers.
    logic [15:0] r_dist_th, r_intv_th, r_base;

    // Captured request.
    logic [2:0]  r_func;
    logic [31:0] r_mm;
    logic        r_ok;
    logic [2:0]  r_oslot;
    logic [15:0] r_magic;
    logic [31:0] r_rseq, r_rtot, r_rtrip;
    logic [7:0]  r_rres, r_rcs;

    // Whole metres of the captured distance.
    logic [31:0] r_metres;

    // Architectural state.
    logic [31:0] r_total, r_trip, r_time, r_saved, r_tss, r_lastseq, r_pend;
    logic [SW-1:0] r_next;
    logic          r_dirty, r_wpend;
    logic          r_bvalid;
    logic [31:0]   r_bseq, r_btot, r_btrip;
    logic [SW-1:0] r_bslot;

    // Products for the average speed.
    logic [DW-1:0] r_num, r_den;

    // Response register.
    logic        r_req, r_found;
    logic [15:0] r_addr, r_avg;
    logic [31:0] r_sseq;
    logic [7:0]  r_scs;

    logic                 div_start;
    logic [DW-1:0]        div_num, div_den, div_quo;
    owsj_pkg::t_div_stat  div_stat;

    logic        accept;
    logic [63:0] mm_prod;
    logic [32:0] add_tot, add_trip;
    logic [31:0] metres, seq_next;
    logic        offer_ok;
    logic [SW-1:0] slot_inc, bslot_inc;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // The divider serves the average speed only.
    always_comb begin
        div_start = (r_state == S_AVGGO);
        div_num   = r_num;
        div_den   = r_den;
    end

    owsj_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    assign mm_prod   = 64'(r_mm) * 64'(owsj_pkg::MM_RECIP);
    assign metres    = r_metres;
    assign add_tot   = {1'b0, r_total} + {1'b0, metres};
    assign add_trip  = {1'b0, r_trip} + {1'b0, metres};
    assign seq_next  = r_lastseq + 32'd1;
    assign slot_inc  = (32'(r_next) == 32'(owsj_pkg::SLOT_COUNT - 1)) ? '0 : r_next + 1'b1;
    assign bslot_inc = (32'(r_bslot) == 32'(owsj_pkg::SLOT_COUNT - 1)) ? '0 : r_bslot + 1'b1;
    assign offer_ok  = (32'(r_oslot) < 32'(owsj_pkg::SLOT_COUNT))
                       && (r_magic == owsj_pkg::REC_MAGIC)
                       && (owsj_pkg::rec_csum(r_magic, r_rseq, r_rtot, r_rtrip, r_rres)
                           == r_rcs);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_req.func == owsj_pkg::FN_ADD) ? S_MMCONV : S_APPLY;
                    end
                end
                S_MMCONV: r_state <= S_APPLY;
                S_APPLY:  r_state <= S_MUL;
                S_MUL:    r_state <= (r_time == 32'd0) ? S_OUT : S_AVGGO;
                S_AVGGO:  r_state <= S_DIVAVG;
                S_DIVAVG: begin
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_mm    <= i_req.distance_mm;
            r_ok    <= i_req.write_ok;
            r_oslot <= i_req.offered_slot;
            r_magic <= i_req.rec_magic;
            r_rseq  <= i_req.rec_seq;
            r_rtot  <= i_req.rec_total;
            r_rtrip <= i_req.rec_trip;
            r_rres  <= i_req.rec_reserved;
            r_rcs   <= i_req.rec_checksum;
        end
    end

    // Millimetres to whole metres by reciprocal multiplication.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MMCONV) begin
            r_metres <= 32'(mm_prod[63:owsj_pkg::MM_RECIP_SH]);
        end
    end

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_th <= owsj_pkg::DIST_RESET;
            r_intv_th <= owsj_pkg::INTV_RESET;
            r_base    <= owsj_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                owsj_pkg::CFG_DIST: r_dist_th <= i_cfg_data;
                owsj_pkg::CFG_INTV: r_intv_th <= i_cfg_data;
                owsj_pkg::CFG_BASE: r_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // State update, one request per pass through S_APPLY.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0; r_trip <= '0; r_time <= '0; r_saved <= '0;
            r_tss <= '0; r_lastseq <= '0; r_next <= '0; r_dirty <= 1'b0;
            r_wpend <= 1'b0; r_pend <= '0; r_bvalid <= 1'b0; r_bseq <= '0;
            r_btot <= '0; r_btrip <= '0; r_bslot <= '0;
            r_req <= 1'b0; r_found <= 1'b0; r_addr <= '0; r_sseq <= '0; r_scs <= '0;
        end else if (r_state == S_APPLY) begin
            r_req   <= 1'b0;
            r_found <= 1'b0;
            r_addr  <= '0;
            r_sseq  <= '0;
            r_scs   <= '0;
            unique case (r_func)
                owsj_pkg::FN_ADD: begin
                    if (metres != 32'd0) begin
                        r_total <= add_tot[32] ? 32'hFFFF_FFFF : add_tot[31:0];
                        r_trip  <= add_trip[32] ? 32'hFFFF_FFFF : add_trip[31:0];
                        if (((add_tot[32] ? 32'hFFFF_FFFF : add_tot[31:0]) - r_saved)
                            >= 32'(r_dist_th)) begin
                            r_dirty <= 1'b1;
                        end
                    end
                end
                owsj_pkg::FN_TICK: begin
                    r_time <= r_time + 32'd1;
                    r_tss  <= r_tss + 32'd1;
                    if ((r_tss + 32'd1) >= 32'(r_intv_th)) begin
                        r_dirty <= 1'b1;
                    end
                end
                owsj_pkg::FN_SAVE: begin
                    if (r_dirty || r_total != r_saved) begin
                        r_req   <= 1'b1;
                        r_sseq  <= seq_next;
                        r_addr  <= 16'(32'(r_base) + (32'(r_next) << owsj_pkg::SLOT_BYTES_SH));
                        r_scs   <= owsj_pkg::rec_csum(owsj_pkg::REC_MAGIC, seq_next,
                                                      r_total, r_trip, 8'd0);
                        r_pend  <= r_total;
                        r_wpend <= 1'b1;
                    end
                end
                owsj_pkg::FN_TRIPCLR: begin
                    r_trip  <= '0;
                    r_time  <= '0;
                    r_dirty <= 1'b1;
                end
                owsj_pkg::FN_WDONE: begin
                    if (r_wpend && r_ok) begin
                        r_lastseq <= seq_next;
                        r_saved   <= r_pend;
                        r_tss     <= '0;
                        r_next    <= slot_inc;
                        r_dirty   <= 1'b0;
                    end
                    r_wpend <= 1'b0;
                end
                owsj_pkg::FN_OFFER: begin
                    if (offer_ok && (!r_bvalid || r_rseq > r_bseq)) begin
                        r_bvalid <= 1'b1;
                        r_bseq   <= r_rseq;
                        r_btot   <= r_rtot;
                        r_btrip  <= r_rtrip;
                        r_bslot  <= SW'(r_oslot);
                    end
                end
                owsj_pkg::FN_FINISH: begin
                    r_time <= '0;
                    r_tss  <= '0;
                    if (r_bvalid) begin
                        r_total   <= r_btot;
                        r_trip    <= r_btrip;
                        r_saved   <= r_btot;
                        r_lastseq <= r_bseq;
                        r_next    <= bslot_inc;
                        r_found   <= 1'b1;
                    end else begin
                        r_total   <= '0;
                        r_trip    <= '0;
                        r_saved   <= '0;
                        r_lastseq <= '0;
                        r_next    <= '0;
                    end
                    r_dirty  <= 1'b0;
                    r_wpend  <= 1'b0;
                    r_bvalid <= 1'b0;
                    r_bseq   <= '0;
                    r_btot   <= '0;
                    r_btrip  <= '0;
                    r_bslot  <= '0;
                end
                default: ;
            endcase
        end
    end

    // Average speed: products registered, then divided; saturates at 16 bits.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_num <= DW'(r_trip) * DW'(owsj_pkg::SEC_PER_H);
            r_den <= DW'(r_time) * DW'(owsj_pkg::MM_PER_M);
            r_avg <= '0;
        end else if (r_state == S_DIVAVG && div_stat.done) begin
            r_avg <= (div_quo[DW-1:16] != '0) ? 16'hFFFF : div_quo[15:0];
        end
    end

    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.total_metres  = r_total;
    assign o_rsp.trip_metres   = r_trip;
    assign o_rsp.trip_seconds  = r_time;
    assign o_rsp.trip_avg_kmh  = r_avg;
    assign o_rsp.save_request  = r_req;
    assign o_rsp.save_address  = r_addr;
    assign o_rsp.save_seq      = r_sseq;
    assign o_rsp.save_checksum = r_scs;
    assign o_rsp.restore_found = r_found;

    // A response with no save request carries a zero sequence.
    `OWSJ_ASSERT_NOW(a_noreq_zero, o_rsp.valid && !o_rsp.save_request, o_rsp.save_seq == 32'd0)
    // An accepted request always moves the sequencer out of idle.
    `OWSJ_ASSERT_NEXT(a_accept_busy, accept, r_state != S_IDLE)
    // The divider only runs while the sequencer waits on it.
    `OWSJ_ASSERT_NOW(a_div_owner, div_stat.busy && !div_start, r_state == S_DIVAVG)
    // The divider is never restarted while busy.
    `OWSJ_ASSERT_NOW(a_div_start, div_start, !div_stat.busy)
endmodule
